/* hdl/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types, codes and defaults of the three-class priority queue server.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;
   localparam int COUNT_BITS_DEF  = 16;

   localparam int NUM_CLASSES = 3;
   localparam int CLASS_BITS  = 2;

   localparam int OP_W     = 2;
   localparam int PRIO_W   = 3;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;
   localparam int TOTAL_W  = 16;

   localparam logic [OP_W-1:0] OP_ADMIT = 2'd0;
   localparam logic [OP_W-1:0] OP_SERVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [PRIO_W-1:0] PRIO_HIGH = 3'd1;
   localparam logic [PRIO_W-1:0] PRIO_LOW  = 3'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PRIO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

   localparam logic [CLASS_BITS-1:0] CLASS_NONE = 2'd0;

   typedef logic [CLASS_BITS-1:0] cls_type;

   typedef enum logic [2:0] {
      CMD_ADMIT,
      CMD_SERVE,
      CMD_CLEAR,
      CMD_NOP,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      cls_type          cls;
      logic [TAG_W-1:0] tag;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [TAG_W-1:0]      served_tag;
      logic [CLASS_BITS-1:0] served_class;
      logic [LEN_W-1:0]      high_length;
      logic [LEN_W-1:0]      medium_length;
      logic [LEN_W-1:0]      low_length;
      logic [TOTAL_W-1:0]    total_served;
      logic [TAG_W-1:0]      last_tag;
      logic [CLASS_BITS-1:0] last_class;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/tcpq_if.sv */
// ----------------------------------------------------------------------------
// tcpq_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpq_req_if import tcpq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [PRIO_W-1:0] priority_req;
   logic [TAG_W-1:0]  item_tag;

   modport source (output valid, output op, output priority_req, output item_tag,
                   input ready);
   modport sink   (input valid, input op, input priority_req, input item_tag,
                   output ready);
endinterface

interface tcpq_rsp_if import tcpq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [TAG_W-1:0]      served_tag;
   logic [CLASS_BITS-1:0] served_class;
   logic [LEN_W-1:0]      high_length;
   logic [LEN_W-1:0]      medium_length;
   logic [LEN_W-1:0]      low_length;
   logic [TOTAL_W-1:0]    total_served;
   logic [TAG_W-1:0]      last_tag;
   logic [CLASS_BITS-1:0] last_class;

   modport source (output valid, output status, output served_tag, output served_class,
                   output high_length, output medium_length, output low_length,
                   output total_served, output last_tag, output last_class,
                   input ready);
   modport sink   (input valid, input status, input served_tag, input served_class,
                   input high_length, input medium_length, input low_length,
                   input total_served, input last_tag, input last_class,
                   output ready);
endinterface

`default_nettype wire

/* hdl/tcpq_ram.sv */
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram import tcpq_pkg::*; #(
   parameter int WIDTH = TAG_BITS_DEF,
   parameter int DEPTH = NUM_CLASSES * QUEUE_DEPTH_DEF,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/tcpq_front.sv */
// ----------------------------------------------------------------------------
// tcpq_front
// Accepts requests, decodes them into commands and buffers them in a
// two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_front import tcpq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tcpq_req_if.sink   req_ch,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_ready
);

   localparam int FIFO_DEPTH = 2;

   cmd_type    slot_ff [FIFO_DEPTH];
   cmd_type    slot_in [FIFO_DEPTH];
   logic [1:0] fill_ff, fill_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   cmd_type    cmd_new;
   logic       push, pop;

   always_comb begin
      cmd_new.tag  = req_ch.item_tag;
      cmd_new.cls  = CLASS_NONE;
      cmd_new.kind = CMD_NOP;
      case (req_ch.op)
         OP_ADMIT: begin
            if (req_ch.priority_req >= PRIO_HIGH && req_ch.priority_req <= PRIO_LOW) begin
               cmd_new.kind = CMD_ADMIT;
               cmd_new.cls  = CLASS_BITS'(req_ch.priority_req - PRIO_HIGH);
            end else begin
               cmd_new.kind = CMD_REJECT;
            end
         end
         OP_SERVE: cmd_new.kind = CMD_SERVE;
         OP_CLEAR: cmd_new.kind = CMD_CLEAR;
         default:  cmd_new.kind = CMD_NOP;
      endcase
   end

   assign req_ch.ready = (fill_ff != 2'(FIFO_DEPTH));
   assign cmd_valid    = (fill_ff != 2'd0);
   assign cmd          = slot_ff[rd_ptr_ff];
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = cmd_valid && cmd_ready;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = cmd_new;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/tcpq_back.sv */
// ----------------------------------------------------------------------------
// tcpq_back
// Executes commands against the three class queues and the service history,
// and holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_back import tcpq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_ready,
   tcpq_rsp_if.source  rsp_ch
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int RAM_DEPTH  = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_BITS  = $clog2(RAM_DEPTH);

   typedef enum logic {ST_EXEC, ST_FETCH} state_type;

   state_type             state_ff, state_in;
   logic [PTR_BITS-1:0]   head_ff  [NUM_CLASSES];
   logic [PTR_BITS-1:0]   head_in  [NUM_CLASSES];
   logic [PTR_BITS-1:0]   tail_ff  [NUM_CLASSES];
   logic [PTR_BITS-1:0]   tail_in  [NUM_CLASSES];
   logic [CNT_BITS-1:0]   count_ff [NUM_CLASSES];
   logic [CNT_BITS-1:0]   count_in [NUM_CLASSES];
   logic [COUNT_BITS-1:0] served_ff, served_in;
   logic                  hist_valid_ff, hist_valid_in;
   logic [STORE_BITS-1:0] hist_tag_ff, hist_tag_in;
   cls_type               hist_class_ff, hist_class_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  slot_free, pop;
   logic                  pick_found;
   cls_type               pick;
   logic                  wr_en, rd_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [STORE_BITS-1:0] rd_data;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      ptr_next = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   tcpq_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (STORE_BITS'(cmd.tag)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ready = (state_ff == ST_EXEC) && slot_free;
   assign pop       = cmd_valid && cmd_ready;

   // strict priority: lowest class index with entries wins
   always_comb begin
      pick_found = 1'b1;
      pick       = 2'd0;
      if (count_ff[0] != '0) begin
         pick = 2'd0;
      end else if (count_ff[1] != '0) begin
         pick = 2'd1;
      end else if (count_ff[2] != '0) begin
         pick = 2'd2;
      end else begin
         pick_found = 1'b0;
      end
   end

   assign wr_addr = ADDR_BITS'(cmd.cls) * ADDR_BITS'(QUEUE_DEPTH)
                    + ADDR_BITS'(tail_ff[cmd.cls]);
   assign rd_addr = ADDR_BITS'(pick) * ADDR_BITS'(QUEUE_DEPTH)
                    + ADDR_BITS'(head_ff[pick]);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      served_in     = served_ff;
      hist_valid_in = hist_valid_ff;
      hist_tag_in   = hist_tag_ff;
      hist_class_in = hist_class_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         ST_EXEC: begin
            if (pop) begin
               rsp_in.status       = STATUS_OK;
               rsp_in.served_tag   = '0;
               rsp_in.served_class = CLASS_NONE;
               case (cmd.kind)
                  CMD_ADMIT: begin
                     if (count_ff[cmd.cls] == CNT_BITS'(QUEUE_DEPTH)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en             = 1'b1;
                        tail_in[cmd.cls]  = ptr_next(tail_ff[cmd.cls]);
                        count_in[cmd.cls] = count_ff[cmd.cls] + 1'b1;
                     end
                  end
                  CMD_REJECT: rsp_in.status = STATUS_BAD_PRIO;
                  CMD_SERVE: begin
                     if (!pick_found) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en               = 1'b1;
                        head_in[pick]       = ptr_next(head_ff[pick]);
                        count_in[pick]      = count_ff[pick] - 1'b1;
                        if (served_ff != '1) begin
                           served_in = served_ff + 1'b1;
                        end
                        hist_valid_in       = 1'b1;
                        hist_class_in       = pick + 2'd1;
                        rsp_in.served_class = pick + 2'd1;
                        state_in            = ST_FETCH;
                     end
                  end
                  CMD_CLEAR: begin
                     served_in     = '0;
                     hist_valid_in = 1'b0;
                     hist_tag_in   = '0;
                     hist_class_in = CLASS_NONE;
                  end
                  default: ;
               endcase
               rsp_in.high_length   = LEN_W'(count_in[0]);
               rsp_in.medium_length = LEN_W'(count_in[1]);
               rsp_in.low_length    = LEN_W'(count_in[2]);
               rsp_in.total_served  = TOTAL_W'(served_in);
               rsp_in.last_tag      = hist_valid_in ? TAG_W'(hist_tag_in) : '0;
               rsp_in.last_class    = hist_valid_in ? hist_class_in : CLASS_NONE;
               rsp_valid_in         = (state_in == ST_EXEC);
            end
         end
         ST_FETCH: begin
            // popped tag arrives in the cycle after the read
            hist_tag_in       = rd_data;
            rsp_in.served_tag = TAG_W'(rd_data);
            rsp_in.last_tag   = TAG_W'(rd_data);
            rsp_valid_in      = 1'b1;
            state_in          = ST_EXEC;
         end
         default: state_in = ST_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= ST_EXEC;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         served_ff     <= '0;
         hist_valid_ff <= 1'b0;
         hist_tag_ff   <= '0;
         hist_class_ff <= CLASS_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         served_ff     <= served_in;
         hist_valid_ff <= hist_valid_in;
         hist_tag_ff   <= hist_tag_in;
         hist_class_ff <= hist_class_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.served_tag    = rsp_ff.served_tag;
   assign rsp_ch.served_class  = rsp_ff.served_class;
   assign rsp_ch.high_length   = rsp_ff.high_length;
   assign rsp_ch.medium_length = rsp_ff.medium_length;
   assign rsp_ch.low_length    = rsp_ff.low_length;
   assign rsp_ch.total_served  = rsp_ff.total_served;
   assign rsp_ch.last_tag      = rsp_ff.last_tag;
   assign rsp_ch.last_class    = rsp_ff.last_class;

endmodule

`default_nettype wire

/* hdl/three_class_priority_queue_server.sv */
// ----------------------------------------------------------------------------
// three_class_priority_queue_server
// Strict-priority scheduler over three tag FIFOs (high, medium, low).
//
//   Channel  Dir  Handshake     Transfer
//   req_ch   in   valid/ready   op, priority_req, item_tag
//   rsp_ch   out  valid/ready   status, served tag/class, queue lengths,
//                               total served, last served tag/class
//
// Admit, clear, reject and no-op commands finish in the back end's execute
// state; a serve with a hit waits in fetch for the registered tag RAM read.
// Requests reach the back end through the registered command queue.
// The two-entry command queue lets up to two requests in while rsp_ch stalls.
// Synchronous reset empties all class queues and the service history; the
// tag RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module three_class_priority_queue_server import tcpq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcpq_req_if.sink    req_ch,
   tcpq_rsp_if.source  rsp_ch
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   tcpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   tcpq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

/* hdl/tcpq_checker.sv */
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks of the priority queue server, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_checker import tcpq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [TAG_W-1:0]      rsp_served_tag,
   input logic [CLASS_BITS-1:0] rsp_served_class,
   input logic [TAG_W-1:0]      rsp_last_tag,
   input logic [CLASS_BITS-1:0] rsp_last_class
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending or request blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_served_tag)
                                  && $stable(rsp_served_class))
      else $error("response changed while stalled");

   a_fail_no_serve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_served_class == CLASS_NONE && rsp_served_tag == '0)
      else $error("failed command reports a served item");

   a_serve_history: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_served_class != CLASS_NONE |->
         rsp_last_class == rsp_served_class && rsp_last_tag == rsp_served_tag)
      else $error("served item not recorded as last served");

endmodule

bind three_class_priority_queue_server tcpq_checker u_tcpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_served_tag   (rsp_ch.served_tag),
   .rsp_served_class (rsp_ch.served_class),
   .rsp_last_tag     (rsp_ch.last_tag),
   .rsp_last_class   (rsp_ch.last_class)
);

`default_nettype wire
